// File: hw/rtl/auto_threshold_binarizer_macros.svh
// ----------------------------------------------------------------------------
// auto_threshold_binarizer_macros
// assertion macros for the checker of the binarizer
// ----------------------------------------------------------------------------
`ifndef AUTO_THRESHOLD_BINARIZER_MACROS_SVH
`define AUTO_THRESHOLD_BINARIZER_MACROS_SVH

// concurrent assertion on clk, off while arst_n is low
`define ATB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same-cycle implication
`define ATB_IMPLIES(lbl, ante, cons, msg) \
	`ATB_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define ATB_NEXT(lbl, ante, cons, msg) \
	`ATB_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: hw/rtl/atb_pkg.sv
// ----------------------------------------------------------------------------
// atb_pkg
// types and constants of the auto threshold binarizer
// ----------------------------------------------------------------------------
package atb_pkg;

	localparam int BIN_BITS   = 8;
	localparam int BIN_COUNT  = 1 << BIN_BITS;
	localparam int COUNT_BITS = 22;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam int WEIGHT_BITS = 16;
	localparam int ACC_BITS    = WEIGHT_BITS + BIN_BITS;
	localparam logic [WEIGHT_BITS-1:0] W_RED   = 16'd19595;
	localparam logic [WEIGHT_BITS-1:0] W_GREEN = 16'd38470;
	localparam logic [WEIGHT_BITS-1:0] W_BLUE  = 16'd7471;

	localparam logic [1:0] LUMA_RED   = 2'd0;
	localparam logic [1:0] LUMA_GREEN = 2'd1;
	localparam logic [1:0] LUMA_BLUE  = 2'd2;

	localparam logic [BIN_BITS-1:0] NO_PEAK_THRESHOLD = 8'd128;
	localparam logic [BIN_BITS-1:0] FIRST_EVAL_IDX    = 8'd2;
	localparam logic [BIN_BITS-1:0] LAST_BIN          = 8'd255;

	localparam int SUM_BITS  = 15;
	localparam int PEAK_BITS = 8;
	localparam logic [3:0] DIV_LAST_STEP = 4'(SUM_BITS - 1);

	localparam logic OP_ACCUMULATE = 1'b0;
	localparam logic OP_CLASSIFY   = 1'b1;
	localparam logic KIND_REPORT   = 1'b0;
	localparam logic KIND_CLASSIFY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LUMA,
		ST_CLASS,
		ST_READ,
		ST_WRITE,
		ST_SCAN,
		ST_DIV,
		ST_REPORT
	} atb_state_t;

	typedef struct packed {
		logic                busy;
		logic                ram_re;
		logic [BIN_BITS-1:0] ram_raddr;
		logic                ram_we;
	} atb_ctrl_t;

endpackage

// File: hw/rtl/atb_ram.sv
// ----------------------------------------------------------------------------
// atb_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module atb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/auto_threshold_binarizer.sv
// ----------------------------------------------------------------------------
// auto_threshold_binarizer
// luminance histogram, peak-mean threshold and pixel binarization
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; each result is
// shown for one cycle with done high and must be captured then. Luminance is
// formed by one shared 16x8 multiplier, a step each for red, green and blue.
// A classify transaction then compares it with the stored threshold; its
// result is shown as busy falls, and the next one can be taken then; an
// accumulate transaction updates its histogram bin by read-modify-write in
// the ram, a read state followed by a write state. An accumulate with last
// set then scans all 256 bins through the single ram read port, divides the
// peak index sum by the peak count one quotient bit per cycle and reports
// the threshold. The histogram is cleared at once by per-bin valid flags, so
// no clearing pass follows reset or a report.
// ----------------------------------------------------------------------------
module auto_threshold_binarizer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         opcode,
	input  logic [atb_pkg::BIN_BITS-1:0] red,
	input  logic [atb_pkg::BIN_BITS-1:0] green,
	input  logic [atb_pkg::BIN_BITS-1:0] blue,
	input  logic                         last,
	output logic                         done,
	output logic                         kind,
	output logic [atb_pkg::BIN_BITS-1:0] threshold_value,
	output logic                         is_white
);

	import atb_pkg::*;

	atb_state_t state_q, state_d;
	atb_ctrl_t  ctrl;

	logic                   opcode_q, last_q;
	logic [BIN_BITS-1:0]    red_q, green_q, blue_q;
	logic [1:0]             step_q;
	logic [ACC_BITS-1:0]    acc_q;
	logic [BIN_COUNT-1:0]   hist_valid_q;
	logic [BIN_BITS:0]      scan_addr_q;
	logic                   scan_vld_s1, scan_hv_s1;
	logic [BIN_BITS-1:0]    scan_idx_s1;
	logic [COUNT_BITS-1:0]  win0_q, win1_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic [PEAK_BITS-1:0]   peaks_q;
	logic [PEAK_BITS-1:0]   rem_q;
	logic [3:0]             div_cnt_q;
	logic [BIN_BITS-1:0]    thresh_q;
	logic                   done_q, kind_q, white_q;
	logic [BIN_BITS-1:0]    thr_out_q;

	logic [WEIGHT_BITS-1:0] mul_w;
	logic [BIN_BITS-1:0]    mul_c;
	logic [ACC_BITS-1:0]    mul_p;
	logic [BIN_BITS-1:0]    luma;
	logic [COUNT_BITS-1:0]  ram_rdata, old_count, new_count, cur_count;
	logic                   peak_hit, scan_end;
	logic [PEAK_BITS:0]     trial;
	logic                   trial_ge;
	logic [BIN_BITS-1:0]    report_thr;

	// shared multiplier
	always_comb begin
		unique case (step_q)
			LUMA_RED:   begin mul_w = W_RED;   mul_c = red_q;   end
			LUMA_GREEN: begin mul_w = W_GREEN; mul_c = green_q; end
			default:    begin mul_w = W_BLUE;  mul_c = blue_q;  end
		endcase
	end
	assign mul_p = ACC_BITS'(mul_w) * ACC_BITS'(mul_c);
	assign luma  = acc_q[ACC_BITS-1 -: BIN_BITS];

	assign old_count = hist_valid_q[luma] ? ram_rdata : '0;
	assign new_count = (old_count == COUNT_MAX) ? old_count : old_count + 1'b1;
	assign cur_count = scan_hv_s1 ? ram_rdata : '0;
	assign peak_hit  = scan_vld_s1 && (scan_idx_s1 >= FIRST_EVAL_IDX)
	                   && (win1_q > win0_q) && (win1_q > cur_count);
	assign scan_end  = scan_vld_s1 && (scan_idx_s1 == LAST_BIN);

	assign trial      = {rem_q, sum_q[SUM_BITS-1]};
	assign trial_ge   = trial >= {1'b0, peaks_q};
	assign report_thr = (peaks_q == '0) ? NO_PEAK_THRESHOLD : sum_q[BIN_BITS-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_LUMA;
			ST_LUMA: begin
				if (step_q == LUMA_BLUE) begin
					state_d = (opcode_q == OP_CLASSIFY) ? ST_CLASS : ST_READ;
				end
			end
			ST_CLASS:  state_d = ST_IDLE;
			ST_READ:   state_d = ST_WRITE;
			ST_WRITE:  state_d = last_q ? ST_SCAN : ST_IDLE;
			ST_SCAN:   if (scan_end) state_d = ST_DIV;
			ST_DIV:    if (div_cnt_q == DIV_LAST_STEP) state_d = ST_REPORT;
			ST_REPORT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ctrl           = '0;
		ctrl.busy      = (state_q != ST_IDLE);
		ctrl.ram_raddr = luma;
		unique case (state_q)
			ST_READ:  ctrl.ram_re = 1'b1;
			ST_WRITE: ctrl.ram_we = 1'b1;
			ST_SCAN: begin
				ctrl.ram_re    = !scan_addr_q[BIN_BITS];
				ctrl.ram_raddr = scan_addr_q[BIN_BITS-1:0];
			end
			default: ;
		endcase
	end

	atb_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(BIN_COUNT)
	) u_hist_ram (
		.clk  (clk),
		.we   (ctrl.ram_we),
		.waddr(luma),
		.wdata(new_count),
		.re   (ctrl.ram_re),
		.raddr(ctrl.ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done_q       <= 1'b0;
			hist_valid_q <= '0;
			thresh_q     <= NO_PEAK_THRESHOLD;
			scan_vld_s1  <= 1'b0;
		end else begin
			state_q     <= state_d;
			done_q      <= (state_q == ST_CLASS) || (state_q == ST_REPORT);
			scan_vld_s1 <= (state_q == ST_SCAN) && ctrl.ram_re;
			if (state_q == ST_WRITE) begin
				hist_valid_q[luma] <= 1'b1;
			end
			if (state_q == ST_REPORT) begin
				hist_valid_q <= '0;
				thresh_q     <= report_thr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			opcode_q <= opcode;
			last_q   <= last;
			red_q    <= red;
			green_q  <= green;
			blue_q   <= blue;
			step_q   <= LUMA_RED;
		end
		if (state_q == ST_LUMA) begin
			step_q <= step_q + 1'b1;
			acc_q  <= ((step_q == LUMA_RED) ? '0 : acc_q) + mul_p;
		end
		if (state_q == ST_WRITE) begin
			scan_addr_q <= '0;
			sum_q       <= '0;
			peaks_q     <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (ctrl.ram_re) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			scan_idx_s1 <= scan_addr_q[BIN_BITS-1:0];
			scan_hv_s1  <= hist_valid_q[scan_addr_q[BIN_BITS-1:0]];
			if (scan_vld_s1) begin
				win0_q <= win1_q;
				win1_q <= cur_count;
			end
			if (peak_hit) begin
				sum_q   <= sum_q + SUM_BITS'(scan_idx_s1 - 1'b1);
				peaks_q <= peaks_q + 1'b1;
			end
			rem_q     <= '0;
			div_cnt_q <= '0;
		end
		if (state_q == ST_DIV) begin
			sum_q     <= {sum_q[SUM_BITS-2:0], trial_ge};
			rem_q     <= trial_ge ? PEAK_BITS'(trial - {1'b0, peaks_q}) : trial[PEAK_BITS-1:0];
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if (state_q == ST_CLASS) begin
			kind_q    <= KIND_CLASSIFY;
			thr_out_q <= thresh_q;
			white_q   <= (luma >= thresh_q);
		end
		if (state_q == ST_REPORT) begin
			kind_q    <= KIND_REPORT;
			thr_out_q <= report_thr;
			white_q   <= 1'b0;
		end
	end

	assign busy            = ctrl.busy;
	assign done            = done_q;
	assign kind            = kind_q;
	assign threshold_value = thr_out_q;
	assign is_white        = white_q;

endmodule

// File: hw/rtl/atb_checker.sv
// ----------------------------------------------------------------------------
// atb_checker
// port-level assertions for the auto threshold binarizer
// ----------------------------------------------------------------------------
`include "auto_threshold_binarizer_macros.svh"

module atb_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic opcode,
	input logic done,
	input logic kind,
	input logic is_white
);

	import atb_pkg::*;

	`ATB_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
	`ATB_IMPLIES(a_done_idle, done, !busy, "result shown while busy")
	`ATB_IMPLIES(a_report_black, done && (kind == KIND_REPORT), !is_white, "report with is_white set")
	`ATB_ASSERT(a_class_latency, start && !busy && (opcode == OP_CLASSIFY) |-> ##5 (done && (kind == KIND_CLASSIFY)), "classify result late")

endmodule

bind auto_threshold_binarizer atb_checker u_atb_checker (.*);
